>>> hdl/itoa_pkg.sv
// shared types, constants and helpers for the integer to ascii converter
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_STEP  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [RADIX_W-1:0] base;
    } job_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX)
        begin
            c = CHAR_W'(d) + CH_A - CHAR_W'(RADIX_DEC);
        end
        else
        begin
            c = CHAR_W'(d) + CH_ZERO;
        end
        return c;
    endfunction

endpackage

>>> hdl/integer_to_ascii_radix.sv
// top level of the integer to ascii converter, bases two to thirty-six
//
// usage: present number and pulse start; the word is taken at a clock edge
// with start high and busy low. busy is high while the two-entry job queue
// is full. each character leaves on ascii_char for exactly one cycle with
// char_strobe high; is_last marks the final character of a number. base-ten
// negatives get a leading '-', other bases treat the value as unsigned.
// radix is written through cfg_we/cfg_wdata while idle; values below two
// or above thirty-six saturate. reset sets radix to ten and empties the
// queue and the converter.
// timing: a word passes through the job queue, then the shared divider
// produces its digits one after another, then a setup state (sign or
// read) comes before one character per cycle. the divider loop sets
// the rate; the receiver cannot stall the output.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] number,
    input  logic                          cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]  cfg_wdata,
    output logic                          char_strobe,
    output logic [itoa_pkg::CHAR_W-1:0]   ascii_char,
    output logic                          is_last
);

    itoa_pkg::job_ctrl_t    job;
    logic [VALUE_WIDTH-1:0] job_value;
    logic                   job_pop;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .number    (number),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job       (job),
        .job_value (job_value),
        .job_pop   (job_pop)
    );

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_value   (job_value),
        .job_pop     (job_pop),
        .char_strobe (char_strobe),
        .ascii_char  (ascii_char),
        .is_last     (is_last)
    );

endmodule

>>> hdl/itoa_ram.sv
// generic single write port ram with registered read
module itoa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/itoa_front.sv
// front end: radix register, word classification and job queue
module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] number,
    input  logic                          cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]  cfg_wdata,
    output itoa_pkg::job_ctrl_t           job,
    output logic [VALUE_WIDTH-1:0]        job_value,
    input  logic                          job_pop
);

    localparam int PTR_W = (itoa_pkg::QUEUE_DEPTH > 1) ? $clog2(itoa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(itoa_pkg::QUEUE_DEPTH + 1);

    logic [itoa_pkg::RADIX_W-1:0] radix_reg;
    logic [PTR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic [VALUE_WIDTH-1:0]       value_mem [itoa_pkg::QUEUE_DEPTH];
    logic                         neg_mem   [itoa_pkg::QUEUE_DEPTH];
    logic [itoa_pkg::RADIX_W-1:0] base_mem  [itoa_pkg::QUEUE_DEPTH];

    logic                         push;
    logic [itoa_pkg::RADIX_W-1:0] base_sat;
    logic                         neg_in;
    logic [VALUE_WIDTH-1:0]       value_in;

    // saturate radix and fold base-ten negatives to sign plus magnitude
    always_comb
    begin
        if (radix_reg < itoa_pkg::RADIX_MIN)
        begin
            base_sat = itoa_pkg::RADIX_MIN;
        end
        else if (radix_reg > itoa_pkg::RADIX_MAX)
        begin
            base_sat = itoa_pkg::RADIX_MAX;
        end
        else
        begin
            base_sat = radix_reg;
        end
        neg_in   = (base_sat == itoa_pkg::RADIX_DEC) && number[VALUE_WIDTH-1];
        value_in = neg_in ? ('0 - VALUE_WIDTH'(number)) : VALUE_WIDTH'(number);
    end

    assign busy = (count_reg == CNT_W'(itoa_pkg::QUEUE_DEPTH));
    assign push = start && !busy;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = job_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(job_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= itoa_pkg::RADIX_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_mem[wr_ptr_reg] <= value_in;
            neg_mem[wr_ptr_reg]   <= neg_in;
            base_mem[wr_ptr_reg]  <= base_sat;
        end
    end

    always_comb
    begin
        job.valid = (count_reg != '0);
        job.neg   = neg_mem[rd_ptr_reg];
        job.base  = base_mem[rd_ptr_reg];
        job_value = value_mem[rd_ptr_reg];
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(itoa_pkg::QUEUE_DEPTH))
        else $error("job queue overfilled");

endmodule

>>> hdl/itoa_back.sv
// back end: shared digit divider, digit store and character emitter
module itoa_back #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  itoa_pkg::job_ctrl_t          job,
    input  logic [VALUE_WIDTH-1:0]       job_value,
    output logic                         job_pop,
    output logic                         char_strobe,
    output logic [itoa_pkg::CHAR_W-1:0]  ascii_char,
    output logic                         is_last
);

    localparam int STEP  = itoa_pkg::DIGIT_STEP;
    localparam int NSTEP = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PW    = NSTEP * STEP;
    localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int CW    = $clog2(VALUE_WIDTH + 1);
    localparam int AW    = $clog2(VALUE_WIDTH);
    localparam int RW    = itoa_pkg::RADIX_W;

    itoa_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0]                div_reg, div_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [SCW-1:0]               step_reg, step_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         neg_reg, neg_next;
    logic [RW-1:0]                base_reg, base_next;
    logic                         strobe_reg, strobe_next;
    logic [itoa_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;

    logic [PW-1:0]                div_step;
    logic [RW-1:0]                rem_step;
    logic                         step_last;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [RW-1:0]                ram_rdata;
    logic [CW-1:0]                rd_ptr;

    // restoring division, STEP quotient bits per cycle
    always_comb
    begin
        logic [RW:0]   r;
        logic [PW-1:0] d;
        r = {1'b0, rem_reg};
        d = div_reg;
        for (int i = 0; i < STEP; i++)
        begin
            r = {r[RW-1:0], d[PW-1]};
            d = {d[PW-2:0], 1'b0};
            if (r >= {1'b0, base_reg})
            begin
                r    = r - {1'b0, base_reg};
                d[0] = 1'b1;
            end
        end
        div_step = d;
        rem_step = r[RW-1:0];
    end

    assign step_last = (step_reg == SCW'(NSTEP - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::BK_IDLE:
            begin
                if (job.valid)
                begin
                    state_next = itoa_pkg::BK_DIV;
                end
            end
            itoa_pkg::BK_DIV:
            begin
                if (step_last && (div_step == '0))
                begin
                    state_next = neg_reg ? itoa_pkg::BK_SIGN : itoa_pkg::BK_READ;
                end
            end
            itoa_pkg::BK_SIGN:
            begin
                state_next = itoa_pkg::BK_EMIT;
            end
            itoa_pkg::BK_READ:
            begin
                state_next = itoa_pkg::BK_EMIT;
            end
            itoa_pkg::BK_EMIT:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = itoa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_next    = div_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        job_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[AW-1:0];
        rd_ptr      = cnt_reg - CW'(2);
        case (state_reg)
            itoa_pkg::BK_IDLE:
            begin
                if (job.valid)
                begin
                    job_pop   = 1'b1;
                    div_next  = PW'(job_value);
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = '0;
                    neg_next  = job.neg;
                    base_next = job.base;
                end
            end
            itoa_pkg::BK_DIV:
            begin
                div_next  = div_step;
                rem_next  = rem_step;
                step_next = step_reg + SCW'(1);
                if (step_last)
                begin
                    ram_we    = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            itoa_pkg::BK_SIGN:
            begin
                rd_ptr      = cnt_reg - CW'(1);
                strobe_next = 1'b1;
                char_next   = itoa_pkg::CH_MINUS;
            end
            itoa_pkg::BK_READ:
            begin
                rd_ptr = cnt_reg - CW'(1);
            end
            itoa_pkg::BK_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = itoa_pkg::digit_char(ram_rdata);
                last_next   = (cnt_reg == CW'(1));
                cnt_next    = cnt_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
        ram_raddr = rd_ptr[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itoa_pkg::BK_IDLE;
            step_reg   <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            neg_reg    <= neg_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        char_reg <= char_next;
    end

    itoa_ram #(
        .WIDTH (RW),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rem_step),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign char_strobe = strobe_reg;
    assign ascii_char  = char_reg;
    assign is_last     = last_reg;

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe && is_last |=> !char_strobe)
        else $error("word emitted right after final character");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itoa_pkg::BK_EMIT |-> cnt_reg != '0)
        else $error("emit with empty digit store");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> cnt_reg < CW'(VALUE_WIDTH))
        else $error("digit store overflow");

    a_sign_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itoa_pkg::BK_SIGN |-> neg_reg && base_reg == itoa_pkg::RADIX_DEC)
        else $error("minus sign outside base ten");

endmodule
